>>> hdl/lsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types and constants of the eight-channel line sensor centroid unit.
// ----------------------------------------------------------------------------
package lsc_pkg;

    localparam int CHANNELS            = 8;
    localparam int ERROR_FRACTION_BITS = 14;

    // configuration register indexes
    localparam logic [2:0] REG_BLACK_LO   = 3'd0;
    localparam logic [2:0] REG_BLACK_HI   = 3'd1;
    localparam logic [2:0] REG_WHITE_LO   = 3'd2;
    localparam logic [2:0] REG_WHITE_HI   = 3'd3;
    localparam logic [2:0] REG_FULL_SCALE = 3'd4;
    localparam logic [2:0] REG_LINE_WHITE = 3'd5;
    localparam logic [2:0] REG_NO_LINE    = 3'd6;

    // status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_CAL     = 2'd1;
    localparam logic [1:0] ST_READ_FAILED = 2'd2;

    typedef struct packed {
        logic [15:0] raw_ch0;
        logic [15:0] raw_ch1;
        logic [15:0] raw_ch2;
        logic [15:0] raw_ch3;
        logic [15:0] raw_ch4;
        logic [15:0] raw_ch5;
        logic [15:0] raw_ch6;
        logic [15:0] raw_ch7;
        logic [3:0]  channels_read;
    } frame_t;

    typedef struct packed {
        logic [15:0]        level_ch0;
        logic [15:0]        level_ch1;
        logic [15:0]        level_ch2;
        logic [15:0]        level_ch3;
        logic [15:0]        level_ch4;
        logic [15:0]        level_ch5;
        logic [15:0]        level_ch6;
        logic [15:0]        level_ch7;
        logic [7:0]         line_mask;
        logic [15:0]        peak_strength;
        logic signed [15:0] line_error;
        logic [1:0]         status;
    } result_t;

    typedef struct packed {
        logic capture;
        logic ch_prep;
        logic div_start;
        logic cen_mode;
        logic ch_write;
        logic acc_step;
        logic cen_prep;
        logic cen_write;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic       cal_ok;
        logic [3:0] chan_limit;
        logic       full;
        logic       need_div;
        logic       div_busy;
        logic       total_zero;
    } sts_t;

endpackage
`default_nettype wire

>>> hdl/lsc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsc_div
// Restoring divider, one quotient bit per cycle. The caller must start the
// remainder below the divisor (the block does not enforce it); dividend bits are shifted in MSB first.
// ----------------------------------------------------------------------------
module lsc_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [4:0]  steps,
    input  wire logic [21:0] rem_init,
    input  wire logic [15:0] low_bits,
    input  wire logic [21:0] den,
    output logic             busy,
    output logic [15:0]      quot
);

    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [21:0] rem_reg, rem_next;
    logic [15:0] low_reg, low_next;
    logic [15:0] quot_reg, quot_next;
    logic [21:0] den_reg, den_next;
    logic [22:0] r2;
    logic [22:0] diff;
    logic        ge;

    always_comb
    begin
        r2        = {rem_reg, low_reg[15]};
        ge        = r2 >= {1'b0, den_reg};
        diff      = r2 - {1'b0, den_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = steps;
            rem_next  = rem_init;
            low_next  = low_bits;
            quot_next = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[21:0] : r2[21:0];
            low_next  = {low_reg[14:0], 1'b0};
            quot_next = {quot_reg[14:0], ge};
            cnt_next  = cnt_reg - 5'd1;
            busy_next = cnt_reg != 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule
`default_nettype wire

>>> hdl/lsc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsc_datapath
// Calibration registers, level and mask store, per-channel scaling,
// weight accumulation and centroid error.
// ----------------------------------------------------------------------------
module lsc_datapath #(
    parameter int ERROR_FRACTION_BITS = lsc_pkg::ERROR_FRACTION_BITS
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_wr_en,
    input  wire logic [2:0]      cfg_index,
    input  wire logic [63:0]     cfg_data,
    input  wire lsc_pkg::frame_t frame,
    input  wire lsc_pkg::cmd_t   cmd,
    input  wire logic [2:0]      ch,
    output lsc_pkg::sts_t        sts,
    output lsc_pkg::result_t     result
);

    logic [63:0]        black_lo_reg, black_hi_reg, white_lo_reg, white_hi_reg;
    logic [15:0]        fs_reg;
    logic               liw_reg;
    logic [15:0]        no_line_reg;

    logic [15:0]        raw_reg [8];
    logic [15:0]        level_reg [8];
    logic [7:0]         mask_reg;
    logic [3:0]         limit_reg;
    logic               full_reg;
    logic [1:0]         status_reg;

    logic [31:0]        prod_reg;
    logic [15:0]        range_reg;
    logic               below_reg, above_reg;

    logic [18:0]        total_reg;
    logic [21:0]        wsum_reg;
    logic [15:0]        peak_reg;
    logic [21:0]        mag_reg, den_reg;
    logic               neg_reg, eq_reg;
    logic [15:0]        err_reg;

    // channel fields
    logic [127:0]       blk_all, wht_all;
    logic [15:0]        blk, wht, raw, dd, rng;
    logic               cal_ok;
    logic               ge_blk;
    logic [17:0]        d3;
    logic [16:0]        r2x;
    logic               hi_hit, lo_hit;

    // accumulation
    logic [15:0]        lvl, clamped, w;
    logic [23:0]        num;
    logic [21:0]        den7;
    logic [21:0]        mag;

    // divider
    logic               div_busy;
    logic [15:0]        quot;
    logic [21:0]        div_rem_init, div_den;
    logic [15:0]        div_low;
    logic [4:0]         div_steps;
    logic [15:0]        qmag;

    assign blk_all = {black_hi_reg, black_lo_reg};
    assign wht_all = {white_hi_reg, white_lo_reg};

    always_comb
    begin
        cal_ok = fs_reg != 16'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (wht_all[i*16 +: 16] <= blk_all[i*16 +: 16])
                cal_ok = 1'b0;
        end
    end

    assign blk    = blk_all[{ch, 4'd0} +: 16];
    assign wht    = wht_all[{ch, 4'd0} +: 16];
    assign raw    = raw_reg[ch];
    assign ge_blk = raw >= blk;
    assign dd     = raw - blk;
    assign rng    = wht - blk;
    assign d3     = {2'b0, dd} + {1'b0, dd, 1'b0};
    assign r2x    = {rng, 1'b0};
    // raw > black + 2*range/3  <=>  3*d > 2*range
    assign hi_hit = ge_blk && (raw != blk) && (d3 > {1'b0, r2x});
    // raw < black + range/3    <=>  3*d + 3 <= range
    assign lo_hit = !ge_blk || ((d3 + 18'd3) <= {2'b0, rng});

    assign lvl     = level_reg[ch];
    assign clamped = (lvl > fs_reg) ? fs_reg : lvl;
    assign w       = liw_reg ? clamped : fs_reg - clamped;

    assign num  = {1'b0, wsum_reg, 1'b0} - 24'(total_reg) * 24'd7;
    assign den7 = 22'(total_reg) * 22'd7;
    assign mag  = num[23] ? 22'(-num) : num[21:0];

    always_comb
    begin
        if (cmd.cen_mode)
        begin
            div_rem_init = mag_reg;
            div_low      = '0;
            div_den      = den_reg;
            div_steps    = 5'(ERROR_FRACTION_BITS);
        end
        else
        begin
            div_rem_init = {6'd0, prod_reg[31:16]};
            div_low      = prod_reg[15:0];
            div_den      = {6'd0, range_reg};
            div_steps    = 5'd16;
        end
    end

    lsc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .steps    (div_steps),
        .rem_init (div_rem_init),
        .low_bits (div_low),
        .den      (div_den),
        .busy     (div_busy),
        .quot     (quot)
    );

    assign qmag = eq_reg ? 16'(1 << ERROR_FRACTION_BITS) : quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            black_lo_reg <= '0;
            black_hi_reg <= '0;
            white_lo_reg <= '0;
            white_hi_reg <= '0;
            fs_reg       <= '0;
            liw_reg      <= 1'b0;
            no_line_reg  <= '0;
            mask_reg     <= '0;
            limit_reg    <= '0;
            full_reg     <= 1'b0;
            status_reg   <= lsc_pkg::ST_OK;
            for (int i = 0; i < 8; i++)
                level_reg[i] <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    lsc_pkg::REG_BLACK_LO:   black_lo_reg <= cfg_data;
                    lsc_pkg::REG_BLACK_HI:   black_hi_reg <= cfg_data;
                    lsc_pkg::REG_WHITE_LO:   white_lo_reg <= cfg_data;
                    lsc_pkg::REG_WHITE_HI:   white_hi_reg <= cfg_data;
                    lsc_pkg::REG_FULL_SCALE: fs_reg       <= cfg_data[15:0];
                    lsc_pkg::REG_LINE_WHITE: liw_reg      <= cfg_data[0];
                    lsc_pkg::REG_NO_LINE:    no_line_reg  <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (cmd.capture)
            begin
                full_reg  <= frame.channels_read[3];
                limit_reg <= frame.channels_read[3] ? 4'd8 : frame.channels_read;
                if (!cal_ok)
                    status_reg <= lsc_pkg::ST_NOT_CAL;
                else if (!frame.channels_read[3])
                    status_reg <= lsc_pkg::ST_READ_FAILED;
                else
                    status_reg <= lsc_pkg::ST_OK;
            end
            if (cmd.ch_prep)
            begin
                if (hi_hit)
                    mask_reg[ch] <= 1'b1;
                else if (lo_hit)
                    mask_reg[ch] <= 1'b0;
            end
            if (cmd.ch_write)
                level_reg[ch] <= below_reg ? 16'd0 : (above_reg ? fs_reg : quot);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            raw_reg[0] <= frame.raw_ch0;
            raw_reg[1] <= frame.raw_ch1;
            raw_reg[2] <= frame.raw_ch2;
            raw_reg[3] <= frame.raw_ch3;
            raw_reg[4] <= frame.raw_ch4;
            raw_reg[5] <= frame.raw_ch5;
            raw_reg[6] <= frame.raw_ch6;
            raw_reg[7] <= frame.raw_ch7;
            total_reg  <= '0;
            wsum_reg   <= '0;
            peak_reg   <= '0;
            err_reg    <= no_line_reg;
        end
        if (cmd.ch_prep)
        begin
            prod_reg  <= 32'(dd) * 32'(fs_reg);
            range_reg <= rng;
            below_reg <= raw <= blk;
            above_reg <= raw >= wht;
        end
        if (cmd.acc_step)
        begin
            total_reg <= total_reg + 19'(w);
            wsum_reg  <= wsum_reg + 22'(w) * 22'(ch);
            if (w > peak_reg)
                peak_reg <= w;
        end
        if (cmd.cen_prep)
        begin
            mag_reg <= mag;
            den_reg <= den7;
            neg_reg <= num[23];
            eq_reg  <= mag == den7;
        end
        if (cmd.cen_write)
            err_reg <= neg_reg ? 16'(-qmag) : qmag;
        if (cmd.out_load)
        begin
            result.level_ch0     <= level_reg[0];
            result.level_ch1     <= level_reg[1];
            result.level_ch2     <= level_reg[2];
            result.level_ch3     <= level_reg[3];
            result.level_ch4     <= level_reg[4];
            result.level_ch5     <= level_reg[5];
            result.level_ch6     <= level_reg[6];
            result.level_ch7     <= level_reg[7];
            result.line_mask     <= mask_reg;
            result.peak_strength <= peak_reg;
            result.line_error    <= err_reg;
            result.status        <= status_reg;
        end
    end

    always_comb
    begin
        sts.cal_ok     = cal_ok;
        sts.chan_limit = limit_reg;
        sts.full       = full_reg;
        sts.need_div   = !below_reg && !above_reg;
        sts.div_busy   = div_busy;
        sts.total_zero = total_reg == 19'd0;
    end

endmodule
`default_nettype wire

>>> hdl/lsc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsc_ctrl
// Sequencer: walks the read channels, the weight accumulation and the
// centroid division, then hands the word to the output register.
// ----------------------------------------------------------------------------
module lsc_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          frame_valid,
    output logic               frame_stall,
    output logic               result_valid,
    input  wire logic          result_stall,
    input  wire lsc_pkg::sts_t sts,
    output lsc_pkg::cmd_t      cmd,
    output logic [2:0]         ch
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CH_PREP   = 4'd1;
    localparam logic [3:0] S_CH_DIV    = 4'd2;
    localparam logic [3:0] S_CH_WAIT   = 4'd3;
    localparam logic [3:0] S_CH_WRITE  = 4'd4;
    localparam logic [3:0] S_ACC       = 4'd5;
    localparam logic [3:0] S_CEN_PREP  = 4'd6;
    localparam logic [3:0] S_CEN_DIV   = 4'd7;
    localparam logic [3:0] S_CEN_WAIT  = 4'd8;
    localparam logic [3:0] S_CEN_WRITE = 4'd9;
    localparam logic [3:0] S_DONE      = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [3:0] ch_reg, ch_next;
    logic       valid_reg, valid_next;
    logic       accept;

    assign frame_stall = state_reg != S_IDLE;
    assign accept      = frame_valid && !frame_stall;

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        cmd        = '0;
        valid_next = valid_reg && result_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    ch_next     = '0;
                    state_next  = sts.cal_ok ? S_CH_PREP : S_DONE;
                end
            end
            S_CH_PREP:
            begin
                if (ch_reg >= sts.chan_limit)
                begin
                    ch_next    = '0;
                    state_next = sts.full ? S_ACC : S_DONE;
                end
                else
                begin
                    cmd.ch_prep = 1'b1;
                    state_next  = S_CH_DIV;
                end
            end
            S_CH_DIV:
            begin
                if (sts.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_CH_WAIT;
                end
                else
                    state_next = S_CH_WRITE;
            end
            S_CH_WAIT:
            begin
                if (!sts.div_busy)
                    state_next = S_CH_WRITE;
            end
            S_CH_WRITE:
            begin
                cmd.ch_write = 1'b1;
                ch_next      = ch_reg + 4'd1;
                state_next   = S_CH_PREP;
            end
            S_ACC:
            begin
                cmd.acc_step = 1'b1;
                ch_next      = ch_reg + 4'd1;
                if (ch_reg[2:0] == 3'd7)
                    state_next = S_CEN_PREP;
            end
            S_CEN_PREP:
            begin
                cmd.cen_prep = 1'b1;
                state_next   = S_CEN_DIV;
            end
            S_CEN_DIV:
            begin
                cmd.cen_mode = 1'b1;
                if (sts.total_zero)
                    state_next = S_DONE;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_CEN_WAIT;
                end
            end
            S_CEN_WAIT:
            begin
                cmd.cen_mode = 1'b1;
                if (!sts.div_busy)
                    state_next = S_CEN_WRITE;
            end
            S_CEN_WRITE:
            begin
                cmd.cen_write = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!valid_reg || !result_stall)
                begin
                    cmd.out_load = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg    <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            valid_reg <= valid_next;
        end
    end

    assign result_valid = valid_reg;
    assign ch           = ch_reg[2:0];

endmodule
`default_nettype wire

>>> hdl/line_sensor_centroid_8ch_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_sensor_centroid_8ch_unit
// Eight-channel line sensor: calibrated levels, hysteresis mask, peak weight
// and Q-format centroid error.
//
// Input word: eight raw samples and a count of channels read, taken when
// frame_valid is high and frame_stall low. Output word: levels, mask, peak,
// error and status, offered on result_valid until taken with result_stall low.
// One frame is worked at a time. Each read channel whose sample lies between
// the calibration points is scaled by the 16-step shared divider; a sample
// at or beyond a calibration point skips the division. A full frame then
// adds weight accumulation over the eight channels and the centroid
// division; an uncalibrated frame goes straight to the output register.
// The next frame is taken as soon as the result sits in the
// output register, even while the receiver stalls it; a stalled result holds.
// Reset clears configuration, levels, mask and the handshake state.
// Configuration is written through cfg_wr_en / cfg_index / cfg_data.
// ----------------------------------------------------------------------------
module line_sensor_centroid_8ch_unit #(
    parameter int ERROR_FRACTION_BITS = lsc_pkg::ERROR_FRACTION_BITS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [63:0]      cfg_data,
    input  wire logic             frame_valid,
    output logic                  frame_stall,
    input  wire lsc_pkg::frame_t  frame,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output lsc_pkg::result_t      result
);

    lsc_pkg::cmd_t cmd;
    lsc_pkg::sts_t sts;
    logic [2:0]    ch;

    lsc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sts          (sts),
        .cmd          (cmd),
        .ch           (ch)
    );

    lsc_datapath #(
        .ERROR_FRACTION_BITS (ERROR_FRACTION_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .frame     (frame),
        .cmd       (cmd),
        .ch        (ch),
        .sts       (sts),
        .result    (result)
    );

endmodule
`default_nettype wire
